// ===== src/assert_macros.svh =====
// Assertion helpers used by the nearest_marker_assignment RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define NMA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define NMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The expression must never be true.
`define NMA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== src/nma_pkg.sv =====
`default_nettype none

package nma_pkg;

  // Sizes fixed by the point and result formats.
  localparam int MAX_POINTS_DEF = 64;
  localparam int PNT_W          = 6;
  localparam int ID_W           = 6;
  localparam int KIND_W         = 3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_FIXED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARKED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ASSIGNED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NO_MARKER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STATIC    = 3'd4;

  // Microprogram steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_LOAD      = 3'd0;
  localparam logic [STEP_W-1:0] ST_SCAN_INIT = 3'd1;
  localparam logic [STEP_W-1:0] ST_SCAN_RD   = 3'd2;
  localparam logic [STEP_W-1:0] ST_SCAN_WR   = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT_INIT = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT      = 3'd5;

  // Jump conditions.
  localparam logic [1:0] C_ALWAYS = 2'd0;
  localparam logic [1:0] C_TRIG   = 2'd1;
  localparam logic [1:0] C_ZERO   = 2'd2;
  localparam logic [1:0] C_LAST   = 2'd3;

  // Read address selection.
  localparam logic [1:0] A_IDX  = 2'd0;
  localparam logic [1:0] A_DEC  = 2'd1;
  localparam logic [1:0] A_INC  = 2'd2;
  localparam logic [1:0] A_ZERO = 2'd3;

  // Index register operations.
  localparam logic [2:0] I_HOLD = 3'd0;
  localparam logic [2:0] I_LAST = 3'd1;
  localparam logic [2:0] I_DEC  = 3'd2;
  localparam logic [2:0] I_INC  = 3'd3;
  localparam logic [2:0] I_CLR  = 3'd4;

  // One control word of the microprogram.
  typedef struct packed {
    logic              in_rdy;
    logic              wait_out;
    logic              fwd_rd;
    logic              bwd_rd;
    logic              bwd_wr;
    logic              emit;
    logic [1:0]        addr_sel;
    logic [2:0]        idx_op;
    logic [1:0]        cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ucode_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic trig;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } seq_cond_t;

  // Gated controls from the sequencer to the datapath.
  typedef struct packed {
    logic       in_rdy;
    logic       fwd_rd;
    logic       bwd_rd;
    logic       bwd_wr;
    logic       emit;
    logic [1:0] addr_sel;
    logic [2:0] idx_op;
  } dp_ctl_t;

  // Entry written while loading: own flags plus nearest earlier neighbours.
  typedef struct packed {
    logic             fixed;
    logic             marked;
    logic [ID_W-1:0]  id;
    logic             pm_v;
    logic [PNT_W-1:0] pm_idx;
    logic [ID_W-1:0]  pm_id;
    logic [PNT_W-1:0] pf;
  } fwd_ent_t;

  // Entry written by the backward scan: nearest later neighbours.
  typedef struct packed {
    logic             nm_v;
    logic [PNT_W-1:0] nm_idx;
    logic [ID_W-1:0]  nm_id;
    logic [PNT_W-1:0] nf;
  } bwd_ent_t;

  // Microprogram store.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      ST_LOAD: begin
        w.in_rdy = 1'b1;
        w.cond   = C_TRIG;
        w.tgt_t  = ST_SCAN_INIT;
        w.tgt_f  = ST_LOAD;
      end
      ST_SCAN_INIT: begin
        w.idx_op = I_LAST;
        w.cond   = C_ALWAYS;
        w.tgt_t  = ST_SCAN_RD;
        w.tgt_f  = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        w.fwd_rd   = 1'b1;
        w.addr_sel = A_IDX;
        w.cond     = C_ALWAYS;
        w.tgt_t    = ST_SCAN_WR;
        w.tgt_f    = ST_SCAN_WR;
      end
      ST_SCAN_WR: begin
        w.bwd_wr   = 1'b1;
        w.fwd_rd   = 1'b1;
        w.addr_sel = A_DEC;
        w.idx_op   = I_DEC;
        w.cond     = C_ZERO;
        w.tgt_t    = ST_EMIT_INIT;
        w.tgt_f    = ST_SCAN_WR;
      end
      ST_EMIT_INIT: begin
        w.fwd_rd   = 1'b1;
        w.bwd_rd   = 1'b1;
        w.addr_sel = A_ZERO;
        w.idx_op   = I_CLR;
        w.cond     = C_ALWAYS;
        w.tgt_t    = ST_EMIT;
        w.tgt_f    = ST_EMIT;
      end
      ST_EMIT: begin
        w.wait_out = 1'b1;
        w.emit     = 1'b1;
        w.fwd_rd   = 1'b1;
        w.bwd_rd   = 1'b1;
        w.addr_sel = A_INC;
        w.idx_op   = I_INC;
        w.cond     = C_LAST;
        w.tgt_t    = ST_LOAD;
        w.tgt_f    = ST_EMIT;
      end
      default: begin
        w.cond  = C_ALWAYS;
        w.tgt_t = ST_LOAD;
        w.tgt_f = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/nma_ifs.sv =====
`default_nettype none

// Point channel.
interface nma_in_if;
  logic                    valid;
  logic                    ready;
  logic                    is_fixed;
  logic                    is_marked;
  logic [nma_pkg::ID_W-1:0] marker_id;
  logic                    last_point;
  modport source (output valid, is_fixed, is_marked, marker_id, last_point,
                  input ready);
  modport sink (input valid, is_fixed, is_marked, marker_id, last_point,
                output ready);
endinterface

// Result channel.
interface nma_out_if;
  logic                       valid;
  logic                       ready;
  logic [nma_pkg::PNT_W-1:0]  point_index;
  logic [nma_pkg::KIND_W-1:0] kind;
  logic [nma_pkg::ID_W-1:0]   assigned_marker;
  logic [nma_pkg::PNT_W-1:0]  lower_bound_index;
  logic [nma_pkg::PNT_W-1:0]  upper_bound_index;
  logic                       is_static;
  logic                       last_result;
  modport source (output valid, point_index, kind, assigned_marker,
                  lower_bound_index, upper_bound_index, is_static, last_result,
                  input ready);
  modport sink (input valid, point_index, kind, assigned_marker,
                lower_bound_index, upper_bound_index, is_static, last_result,
                output ready);
endinterface

// Configuration write channel for the waypoints_present register.
interface nma_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/nma_ram.sv =====
`default_nettype none

module nma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/nma_seq.sv =====
`default_nettype none

module nma_seq (
  input  logic               clk,
  input  logic               rst,
  input  nma_pkg::seq_cond_t cond,
  output nma_pkg::dp_ctl_t   ctl
);

  import nma_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  logic              go;
  logic              hit;

  // Fetch the control word; a step that waits on the output holds still.
  assign uw = ucode(step);
  assign go = !uw.wait_out || cond.out_free;

  // Jump condition.
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS: hit = 1'b1;
      C_TRIG:   hit = cond.trig;
      C_ZERO:   hit = cond.idx_zero;
      C_LAST:   hit = cond.idx_last;
      default:  hit = 1'b1;
    endcase
  end

  always_comb begin
    if (!go) begin
      step_next = step;
    end else if (hit) begin
      step_next = uw.tgt_t;
    end else begin
      step_next = uw.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

  // Read, write, emit and index controls, suppressed while the step is held.
  assign ctl.in_rdy   = uw.in_rdy;
  assign ctl.fwd_rd   = uw.fwd_rd && go;
  assign ctl.bwd_rd   = uw.bwd_rd && go;
  assign ctl.bwd_wr   = uw.bwd_wr && go;
  assign ctl.emit     = uw.emit && go;
  assign ctl.addr_sel = uw.addr_sel;
  assign ctl.idx_op   = go ? uw.idx_op : I_HOLD;

endmodule

`default_nettype wire

// ===== src/nearest_marker_assignment.sv =====
// Nearest marker assignment for the points of one polyline.
// Points arrive on the pts channel, one transfer per point, with last_point
// set on the final one. After the final point the block runs a backward
// scan over the stored points and then emits one result per point in
// index order on res, one per cycle while res is ready. A line thus takes
// three passes of one point per cycle: load, backward scan and emit.
// pts.ready is high only while loading, so a new line starts once the last
// result has been formed; results are held in an output register, and a
// stall on res freezes the emit pass without losing data.
// Points beyond the store depth are dropped, but a dropped final point still
// starts the scan. The cfg channel writes waypoints_present; it is always
// ready and is meant to be written while no line is in progress.
// Reset clears the register to zero, empties the point count, returns the
// sequencer to loading and drops any pending result. The point stores need
// no clearing.
`default_nettype none
`include "assert_macros.svh"

module nearest_marker_assignment #(
  parameter int MAX_POINTS = nma_pkg::MAX_POINTS_DEF
) (
  input logic      clk,
  input logic      rst,
  nma_cfg_if.sink  cfg,
  nma_in_if.sink   pts,
  nma_out_if.source res
);

  import nma_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam int FWD_W = $bits(fwd_ent_t);
  localparam int BWD_W = $bits(bwd_ent_t);

  dp_ctl_t    ctl;
  seq_cond_t  cond;

  logic             wp;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] raddr;
  logic [PNT_W-1:0] i6;
  logic [PNT_W-1:0] p6;

  logic             accept;
  logic             trig;
  logic             room;
  logic             load_we;

  // Running nearest-neighbour registers for the forward and backward passes.
  logic             run_pm_v;
  logic [PNT_W-1:0] run_pm_idx;
  logic [ID_W-1:0]  run_pm_id;
  logic [PNT_W-1:0] run_pf;
  logic             run_nm_v;
  logic [PNT_W-1:0] run_nm_idx;
  logic [ID_W-1:0]  run_nm_id;
  logic [PNT_W-1:0] run_nf;

  fwd_ent_t         fwd_new;
  fwd_ent_t         fwd_q;
  bwd_ent_t         bwd_new;
  bwd_ent_t         bwd_q;
  logic [FWD_W-1:0] fwd_rdata;
  logic [BWD_W-1:0] bwd_rdata;

  // Result computation.
  logic [KIND_W-1:0] kind_c;
  logic [ID_W-1:0]   marker_c;
  logic [PNT_W-1:0]  lo_c;
  logic [PNT_W-1:0]  hi_c;
  logic [PNT_W-1:0]  dist_p;
  logic [PNT_W-1:0]  dist_n;
  logic [PNT_W-1:0]  lo_max;
  logic [PNT_W-1:0]  hi_min;

  // Output register.
  logic              out_valid;
  logic [PNT_W-1:0]  out_index;
  logic [KIND_W-1:0] out_kind;
  logic [ID_W-1:0]   out_marker;
  logic [PNT_W-1:0]  out_lo;
  logic [PNT_W-1:0]  out_hi;
  logic              out_static;
  logic              out_last;

  // Sequencer.
  nma_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctl  (ctl)
  );

  assign accept = pts.valid && pts.ready;
  assign trig   = accept && pts.last_point;
  assign room   = count < CNT_MAX;
  assign load_we = accept && room;
  assign n_m1   = n - CNT_W'(1);

  assign pts.ready     = ctl.in_rdy;
  assign cond.trig     = trig;
  assign cond.idx_zero = idx == '0;
  assign cond.idx_last = idx == n_m1[IDX_W-1:0];
  assign cond.out_free = !out_valid || res.ready;

  // Configuration register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
    end else if (cfg.valid) begin
      wp <= cfg.data;
    end
  end

  // Forward entry of the incoming point.
  assign p6 = PNT_W'(count[IDX_W-1:0]);

  always_comb begin
    fwd_new.fixed  = pts.is_fixed;
    fwd_new.marked = pts.is_marked;
    fwd_new.id     = pts.marker_id;
    if (pts.is_fixed) begin
      fwd_new.pf = p6;
    end else if (count == '0) begin
      fwd_new.pf = '0;
    end else begin
      fwd_new.pf = run_pf;
    end
    if (pts.is_marked) begin
      fwd_new.pm_v   = 1'b1;
      fwd_new.pm_idx = p6;
      fwd_new.pm_id  = pts.marker_id;
    end else if (count == '0) begin
      fwd_new.pm_v   = 1'b0;
      fwd_new.pm_idx = '0;
      fwd_new.pm_id  = '0;
    end else begin
      fwd_new.pm_v   = run_pm_v;
      fwd_new.pm_idx = run_pm_idx;
      fwd_new.pm_id  = run_pm_id;
    end
  end

  // Point count and line length.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      n     <= '0;
    end else if (trig) begin
      count <= '0;
      n     <= count + CNT_W'(room);
    end else if (load_we) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      run_pm_v   <= fwd_new.pm_v;
      run_pm_idx <= fwd_new.pm_idx;
      run_pm_id  <= fwd_new.pm_id;
      run_pf     <= fwd_new.pf;
    end
  end

  // Index register.
  always_ff @(posedge clk) begin
    unique case (ctl.idx_op)
      I_HOLD:  idx <= idx;
      I_LAST:  idx <= n_m1[IDX_W-1:0];
      I_DEC:   idx <= idx - IDX_W'(1);
      I_INC:   idx <= idx + IDX_W'(1);
      I_CLR:   idx <= '0;
      default: idx <= idx;
    endcase
  end

  // Shared read address of both stores.
  always_comb begin
    unique case (ctl.addr_sel)
      A_IDX:   raddr = idx;
      A_DEC:   raddr = idx - IDX_W'(1);
      A_INC:   raddr = idx + IDX_W'(1);
      A_ZERO:  raddr = '0;
      default: raddr = idx;
    endcase
  end

  nma_ram #(.WIDTH(FWD_W), .DEPTH(MAX_POINTS)) u_fwd_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (fwd_new),
    .re    (ctl.fwd_rd),
    .raddr (raddr),
    .rdata (fwd_rdata)
  );

  assign fwd_q = fwd_ent_t'(fwd_rdata);
  assign i6    = PNT_W'(idx);

  // Backward entry from the stored flags and the later neighbours.
  always_comb begin
    bwd_new.nf = fwd_q.fixed ? i6 : run_nf;
    if (fwd_q.marked) begin
      bwd_new.nm_v   = 1'b1;
      bwd_new.nm_idx = i6;
      bwd_new.nm_id  = fwd_q.id;
    end else begin
      bwd_new.nm_v   = run_nm_v;
      bwd_new.nm_idx = run_nm_idx;
      bwd_new.nm_id  = run_nm_id;
    end
  end

  // The scan starts at the last point with no later marked point and the
  // last index standing in for a missing later fixed point.
  always_ff @(posedge clk) begin
    if (ctl.idx_op == I_LAST) begin
      run_nm_v   <= 1'b0;
      run_nm_idx <= '0;
      run_nm_id  <= '0;
      run_nf     <= PNT_W'(n_m1[IDX_W-1:0]);
    end else if (ctl.bwd_wr) begin
      run_nm_v   <= bwd_new.nm_v;
      run_nm_idx <= bwd_new.nm_idx;
      run_nm_id  <= bwd_new.nm_id;
      run_nf     <= bwd_new.nf;
    end
  end

  nma_ram #(.WIDTH(BWD_W), .DEPTH(MAX_POINTS)) u_bwd_ram (
    .clk   (clk),
    .we    (ctl.bwd_wr),
    .waddr (idx),
    .wdata (bwd_new),
    .re    (ctl.bwd_rd),
    .raddr (raddr),
    .rdata (bwd_rdata)
  );

  assign bwd_q = bwd_ent_t'(bwd_rdata);

  // Classification of one point; the later marked point wins a tie.
  assign dist_p = i6 - fwd_q.pm_idx;
  assign dist_n = bwd_q.nm_idx - i6;
  assign lo_max = (fwd_q.pm_idx > fwd_q.pf) ? fwd_q.pm_idx : fwd_q.pf;
  assign hi_min = (bwd_q.nm_idx < bwd_q.nf) ? bwd_q.nm_idx : bwd_q.nf;

  always_comb begin
    kind_c   = KIND_NO_MARKER;
    marker_c = '0;
    lo_c     = '0;
    hi_c     = '0;
    priority if (!wp) begin
      kind_c = KIND_STATIC;
    end else if (fwd_q.fixed) begin
      kind_c = KIND_FIXED;
    end else if (fwd_q.marked) begin
      kind_c   = KIND_MARKED;
      marker_c = fwd_q.id;
    end else if (fwd_q.pm_v && bwd_q.nm_v) begin
      kind_c   = KIND_ASSIGNED;
      marker_c = (dist_p < dist_n) ? fwd_q.pm_id : bwd_q.nm_id;
      lo_c     = lo_max;
      hi_c     = hi_min;
    end else if (fwd_q.pm_v) begin
      kind_c   = KIND_ASSIGNED;
      marker_c = fwd_q.pm_id;
      lo_c     = lo_max;
      hi_c     = bwd_q.nf;
    end else if (bwd_q.nm_v) begin
      kind_c   = KIND_ASSIGNED;
      marker_c = bwd_q.nm_id;
      lo_c     = fwd_q.pf;
      hi_c     = hi_min;
    end else begin
      kind_c = KIND_NO_MARKER;
    end
  end

  // Output register: filled on emit, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_index  <= i6;
      out_kind   <= kind_c;
      out_marker <= marker_c;
      out_lo     <= lo_c;
      out_hi     <= hi_c;
      out_static <= !wp;
      out_last   <= cond.idx_last;
    end
  end

  assign res.valid             = out_valid;
  assign res.point_index       = out_index;
  assign res.kind              = out_kind;
  assign res.assigned_marker   = out_marker;
  assign res.lower_bound_index = out_lo;
  assign res.upper_bound_index = out_hi;
  assign res.is_static         = out_static;
  assign res.last_result       = out_last;

  // The point count never runs past the store depth.
  `NMA_ASSERT_NEVER(a_count_range, clk, rst, count > CNT_MAX, "point count beyond store depth")

  // While a result other than the last one is pending, no point is taken.
  `NMA_ASSERT_IMPL(a_no_load_midline, clk, rst, res.valid && !res.last_result, !pts.ready, "point taken during emit pass")

  // The backward scan writes only entries of the current line.
  `NMA_ASSERT_IMPL(a_scan_in_line, clk, rst, ctl.bwd_wr, CNT_W'(idx) < n, "scan write beyond line")

  // Emitting the last point leaves a pending result marked last.
  `NMA_ASSERT_NEXT(a_last_marked, clk, rst, ctl.emit && cond.idx_last, out_valid && out_last, "last result not flagged")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nma_pkg::*;

  localparam int LINE_DEPTH = 64;

  // One result as seen on the result channel.
  typedef struct packed {
    logic [PNT_W-1:0]  idx;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   marker;
    logic [PNT_W-1:0]  lo;
    logic [PNT_W-1:0]  hi;
    logic              stat;
    logic              last;
  } result_t;

  // Predicts the results of each line and checks them in order.
  class line_checker;
    bit             waypoints;
    bit [7:0]       flags[LINE_DEPTH];
    bit [6:0]       prev_mark[LINE_DEPTH];
    bit [5:0]       prev_fix[LINE_DEPTH];
    int             count;
    result_t        expected_results[$];
    int             errors;
    int             checked;
    int             lines;
    int             points;

    function int pending();
      return expected_results.size();
    endfunction

    // Called for every accepted point transfer.
    function void note_point(bit fx, bit mk, bit [5:0] id, bit last);
      bit [6:0] next_mark[LINE_DEPTH];
      bit [5:0] next_fix[LINE_DEPTH];
      int       n;
      // Points past the store depth are dropped, but a final one still counts.
      if (count < LINE_DEPTH) begin
        flags[count]     = {id, mk, fx};
        prev_fix[count]  = fx ? 6'(count) : (count == 0 ? 6'd0 : prev_fix[count-1]);
        prev_mark[count] = mk ? {1'b1, 6'(count)} :
                           (count == 0 ? 7'd0 : prev_mark[count-1]);
        count++;
        points++;
      end
      if (!last) return;
      n = count;
      count = 0;
      lines++;
      // Backward scan: nearest later marked and fixed points.
      for (int i = n - 1; i >= 0; i--) begin
        if (flags[i][0]) next_fix[i] = 6'(i);
        else next_fix[i] = (i == n - 1) ? 6'(n - 1) : next_fix[i+1];
        if (flags[i][1]) next_mark[i] = {1'b1, 6'(i)};
        else next_mark[i] = (i == n - 1) ? 7'd0 : next_mark[i+1];
      end
      // One result per stored point, in index order.
      for (int i = 0; i < n; i++) begin
        result_t  r;
        bit [5:0] pmi, nmi, pick;
        pmi    = prev_mark[i][5:0];
        nmi    = next_mark[i][5:0];
        r      = '0;
        r.idx  = 6'(i);
        r.stat = !waypoints;
        r.last = (i == n - 1);
        if (!waypoints) begin
          r.kind = KIND_STATIC;
        end else if (flags[i][0]) begin
          r.kind = KIND_FIXED;
        end else if (flags[i][1]) begin
          r.kind   = KIND_MARKED;
          r.marker = flags[i][7:2];
        end else if (prev_mark[i][6] && next_mark[i][6]) begin
          // Equal distances go to the later marked point.
          pick     = ((i - pmi) < (nmi - i)) ? pmi : nmi;
          r.kind   = KIND_ASSIGNED;
          r.marker = flags[pick][7:2];
          r.lo     = (pmi > prev_fix[i]) ? pmi : prev_fix[i];
          r.hi     = (nmi < next_fix[i]) ? nmi : next_fix[i];
        end else if (prev_mark[i][6]) begin
          r.kind   = KIND_ASSIGNED;
          r.marker = flags[pmi][7:2];
          r.lo     = (pmi > prev_fix[i]) ? pmi : prev_fix[i];
          r.hi     = next_fix[i];
        end else if (next_mark[i][6]) begin
          r.kind   = KIND_ASSIGNED;
          r.marker = flags[nmi][7:2];
          r.lo     = prev_fix[i];
          r.hi     = (nmi < next_fix[i]) ? nmi : next_fix[i];
        end else begin
          r.kind = KIND_NO_MARKER;
        end
        expected_results.insert(expected_results.size(), r);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, int pnt, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("point %0d %s got %0h want %0h", pnt, name, got, want));
    endtask

    // Called for every accepted result transfer.
    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result for point %0d with nothing pending", got.idx));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      check_field("point_index", int'(want.idx), 8'(got.idx), 8'(want.idx));
      check_field("kind", int'(want.idx), 8'(got.kind), 8'(want.kind));
      check_field("assigned_marker", int'(want.idx), 8'(got.marker), 8'(want.marker));
      check_field("lower_bound_index", int'(want.idx), 8'(got.lo), 8'(want.lo));
      check_field("upper_bound_index", int'(want.idx), 8'(got.hi), 8'(want.hi));
      check_field("is_static", int'(want.idx), 8'(got.stat), 8'(want.stat));
      check_field("last_result", int'(want.idx), 8'(got.last), 8'(want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct = 0;
  int   stall_pct = 0;
  line_checker sb;

  nma_cfg_if cfg_if();
  nma_in_if  pts_if();
  nma_out_if res_if();

  nearest_marker_assignment uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .pts (pts_if),
    .res (res_if)
  );

  always #2 clk = ~clk;

  // Result side: check each transfer, then choose whether to stall next cycle.
  always @(posedge clk) begin
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.idx    = res_if.point_index;
      got.kind   = res_if.kind;
      got.marker = res_if.assigned_marker;
      got.lo     = res_if.lower_bound_index;
      got.hi     = res_if.upper_bound_index;
      got.stat   = res_if.is_static;
      got.last   = res_if.last_result;
      sb.check_result(got);
    end
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one point, with random idle cycles in front, until it is taken.
  task send_point(bit fx, bit mk, bit [5:0] id, bit last);
    while ($urandom_range(99) < idle_pct) begin
      pts_if.valid <= 1'b0;
      @(posedge clk);
    end
    pts_if.valid      <= 1'b1;
    pts_if.is_fixed   <= fx;
    pts_if.is_marked  <= mk;
    pts_if.marker_id  <= id;
    pts_if.last_point <= last;
    do @(posedge clk); while (!pts_if.ready);
    sb.note_point(fx, mk, id, last);
  endtask

  // Writes the register once every pending result has come out.
  task write_waypoints(bit v);
    pts_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.waypoints = v;
  endtask

  // A whole line with random content; most lines are short.
  task send_random_line(input int force_len, output int stored);
    int len, style, fx_pct, mk_pct, u;
    u = $urandom_range(99);
    if (force_len != 0) len = force_len;
    else if (u < 3) len = LINE_DEPTH;
    else if (u < 6) len = $urandom_range(LINE_DEPTH + 4, LINE_DEPTH + 1);
    else if (u < 12) len = $urandom_range(40, 13);
    else len = $urandom_range(12, 1);
    // Some lines lack marked or fixed points altogether; some are dense.
    style  = $urandom_range(9);
    fx_pct = (style == 1) ? 0 : $urandom_range(40, 5);
    mk_pct = (style == 0) ? 0 : (style == 2) ? 60 : $urandom_range(35, 5);
    for (int k = 0; k < len; k++)
      send_point($urandom_range(99) < fx_pct, $urandom_range(99) < mk_pct,
                 6'($urandom), k == len - 1);
    stored = (len > LINE_DEPTH) ? LINE_DEPTH : len;
  endtask

  // Stimulus: directed lines, then random phases with different idling.
  initial begin
    int idle_tab[5];
    int stall_tab[5];
    bit wp_tab[5];
    int force_tab[5];
    int stored, total;
    idle_tab  = '{0, 59, 0, 25, 25};
    stall_tab = '{0, 0, 59, 25, 25};
    wp_tab    = '{1, 1, 1, 0, 1};
    force_tab = '{0, 66, 64, 0, 0};
    sb = new;
    rst                <= 1'b1;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= 1'b0;
    pts_if.valid       <= 1'b0;
    pts_if.is_fixed    <= 1'b0;
    pts_if.is_marked   <= 1'b0;
    pts_if.marker_id   <= '0;
    pts_if.last_point  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_waypoints(1'b1);
    // Single plain point: nothing marked anywhere.
    send_point(1'b0, 1'b0, 6'd63, 1'b1);
    // Mixed line: tie between marked neighbours, fixed and marked together,
    // no later fixed point at the tail.
    send_point(1'b1, 1'b0, 6'd0, 1'b0);
    send_point(1'b0, 1'b0, 6'd63, 1'b0);
    send_point(1'b0, 1'b1, 6'd63, 1'b0);
    send_point(1'b0, 1'b0, 6'd17, 1'b0);
    send_point(1'b0, 1'b0, 6'd0, 1'b0);
    send_point(1'b0, 1'b0, 6'd44, 1'b0);
    send_point(1'b0, 1'b1, 6'd0, 1'b0);
    send_point(1'b0, 1'b0, 6'd9, 1'b0);
    send_point(1'b1, 1'b1, 6'd42, 1'b0);
    send_point(1'b0, 1'b0, 6'd63, 1'b0);
    send_point(1'b0, 1'b0, 6'd1, 1'b1);
    // No fixed point at all, one marked point at the head.
    send_point(1'b0, 1'b1, 6'd21, 1'b0);
    send_point(1'b0, 1'b0, 6'd2, 1'b0);
    send_point(1'b0, 1'b0, 6'd3, 1'b1);
    // Fixed and plain points only.
    send_point(1'b0, 1'b0, 6'd5, 1'b0);
    send_point(1'b1, 1'b0, 6'd6, 1'b0);
    send_point(1'b0, 1'b0, 6'd7, 1'b1);
    // Every field at its top value.
    send_point(1'b1, 1'b1, 6'd63, 1'b1);
    // Static line.
    write_waypoints(1'b0);
    send_point(1'b0, 1'b1, 6'd5, 1'b0);
    send_point(1'b0, 1'b0, 6'd0, 1'b0);
    send_point(1'b1, 1'b0, 6'd0, 1'b1);

    // Random phases of at least sixty stored points each.
    for (int ph = 0; ph < 5; ph++) begin
      write_waypoints(wp_tab[ph]);
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      total = 0;
      send_random_line(force_tab[ph], stored);
      total += stored;
      while (total < 60) begin
        send_random_line(0, stored);
        total += stored;
      end
    end
    pts_if.valid <= 1'b0;

    // Drain the remaining results, then let the block settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d stored points in %0d lines, both register values,",
             sb.points, sb.lines);
    $display("%0d results checked under mixed idling; %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/nma_pkg.sv
src/nma_ifs.sv
src/nma_ram.sv
src/nma_seq.sv
src/nearest_marker_assignment.sv
verif/tb.sv
